// ----- src/assert_macros.svh -----
// Assertion helpers used by qdm_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QDM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define QDM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define QDM_ASSERT(label, prop, msg)
`define QDM_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// ----- src/qdm_pkg.sv -----
// ----------------------------------------------------------------------------
// qdm_pkg
// Shared constants, types and functions of the QPSK demodulator.
// ----------------------------------------------------------------------------
package qdm_pkg;

	localparam int TAPS_DEF        = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int PROD_SHIFT      = 3;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_W           = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 2'd2;

	localparam logic [15:0] PHASE_STEP_RST = 16'd8192;
	localparam logic [15:0] BIT_PERIOD_RST = 16'd16;

	// 0.3 rad in 2^-32 turn
	localparam logic [31:0] ANGLE_03 = 32'd205069583;

	// odd sine polynomial, Q30
	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598630;
	localparam logic [31:0] C5 = 32'd85569303;
	localparam logic [31:0] C7 = 32'd5026995;
	localparam logic [31:0] C9 = 32'd172272;

	typedef struct packed {
		logic        start;
		logic [1:0]  quad;
		logic [13:0] frac;
	} sin_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] val;
	} sin_rsp_t;

	// Horner coefficient used at a given step of the sine unit
	function automatic logic [31:0] poly_coef(input logic [2:0] step);
		logic [31:0] c;
		unique case (step)
			3'd1:    c = C7;
			3'd2:    c = C5;
			3'd3:    c = C3;
			default: c = C1;
		endcase
		return c;
	endfunction

	// elaboration-time sine, same arithmetic as the sine unit
	function automatic logic signed [15:0] sin_q15(input logic [31:0] ph);
		logic [1:0]  quad;
		logic [63:0] f;
		logic [63:0] f2;
		logic [63:0] p;
		logic [63:0] r;
		quad = ph[31:30];
		f = {48'd0, ph[29:14]};
		if (quad[0])
			f = 64'd65536 - f;
		f2 = (f * f) >> 16;
		p = {32'd0, C9};
		p = {32'd0, C7} - ((p * f2) >> 16);
		p = {32'd0, C5} - ((p * f2) >> 16);
		p = {32'd0, C3} - ((p * f2) >> 16);
		p = {32'd0, C1} - ((p * f2) >> 16);
		r = (((p * f) >> 16) + 64'd16384) >> 15;
		if (r > 64'd32767)
			r = 64'd32767;
		return quad[1] ? -16'(r) : 16'(r);
	endfunction

endpackage

// ----- src/qdm_fifo.sv -----
// ----------------------------------------------------------------------------
// qdm_fifo
// Two-entry queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module qdm_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;
	logic         do_wr;
	logic         do_rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr)
				wptr_q <= ~wptr_q;
			if (do_rd)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule

// ----- src/qdm_sin.sv -----
// ----------------------------------------------------------------------------
// qdm_sin
// Iterative Q15 sine: six steps per request; result and done are registered together.
// ----------------------------------------------------------------------------
module qdm_sin (
	input  logic              clk,
	input  logic              arst_n,
	input  qdm_pkg::sin_req_t req,
	output qdm_pkg::sin_rsp_t rsp
);

	logic [2:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic signed [15:0] val_q;
	logic [1:0]  quad_q;
	logic [16:0] f_q;
	logic [16:0] f2_q;
	logic [31:0] p_q;
	logic [16:0] f_new;
	logic [33:0] ff;
	logic [48:0] pf2;
	logic [48:0] pf;
	logic [33:0] rsum;
	logic [18:0] r;
	logic [15:0] mag;

	assign f_new = req.quad[0] ? 17'd65536 - {1'b0, req.frac, 2'b00} : {1'b0, req.frac, 2'b00};
	assign ff    = 34'(f_q) * 34'(f_q);
	assign pf2   = 49'(p_q) * 49'(f2_q);
	assign pf    = 49'(p_q) * 49'(f_q);
	assign rsum  = 34'(pf[48:16]) + 34'd16384;
	assign r     = rsum[33:15];
	assign mag   = (r > 19'd32767) ? 16'd32767 : r[15:0];
	assign rsp   = {done_q, val_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			f_q    <= f_new;
			quad_q <= req.quad;
		end else if (busy_q) begin
			if (step_q == 3'd0) begin
				f2_q <= ff[32:16];
				p_q  <= qdm_pkg::C9;
			end else if (step_q != 3'd5) begin
				p_q <= qdm_pkg::poly_coef(step_q) - pf2[47:16];
			end else begin
				val_q <= quad_q[1] ? -$signed(mag) : $signed(mag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == 3'd5);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5)
					busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/qdm_front.sv -----
// ----------------------------------------------------------------------------
// qdm_front
// Takes samples, mixes them with the carrier and hands products to the back.
// ----------------------------------------------------------------------------
module qdm_front #(
	parameter int SAMPLE_BITS = qdm_pkg::SAMPLE_BITS_DEF,
	parameter int PROD_W      = qdm_pkg::SAMPLE_BITS_DEF + 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic signed [SAMPLE_BITS-1:0]    sample,
	output logic                             full,
	input  logic                             cfg_valid,
	input  logic [qdm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qdm_pkg::CFG_W-1:0]        cfg_data,
	output logic                             mid_push,
	output logic [2*PROD_W:0]                mid_data,
	input  logic                             mid_full
);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_COS  = 5'b00010,
		F_SIN  = 5'b00100,
		F_MUL  = 5'b01000,
		F_PUSH = 5'b10000
	} fstate_t;

	localparam int MW = SAMPLE_BITS + 16;
	localparam int PROD_SHIFT_C = qdm_pkg::PROD_SHIFT;

	fstate_t state_q;
	logic [15:0] phase_step_q;
	logic [15:0] bit_period_q;
	logic [15:0] carrier_q;
	logic [16:0] sym_pos_q;
	logic [15:0] item_ph_q;
	logic        emit_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [15:0] c_q;
	logic signed [15:0] s_q;
	logic signed [PROD_W-1:0] pi_q;
	logic signed [PROD_W-1:0] pq_q;
	logic signed [MW-1:0] mul_i;
	logic signed [MW-1:0] mul_q;
	logic        accept;
	logic [15:0] period;
	logic [16:0] pos_next;
	qdm_pkg::sin_req_t sreq;
	qdm_pkg::sin_rsp_t srsp;

	assign full     = (state_q != F_IDLE);
	assign accept   = push && (state_q == F_IDLE);
	assign period   = (bit_period_q == 16'd0) ? 16'd1 : bit_period_q;
	assign pos_next = sym_pos_q + 17'd1;
	assign mul_i    = MW'(x_q) * MW'(c_q);
	assign mul_q    = MW'(x_q) * MW'(s_q);
	assign mid_push = (state_q == F_PUSH) && !mid_full;
	assign mid_data = {emit_q, pi_q, pq_q};

	// cos is sine a quarter turn ahead
	always_comb begin
		sreq.start = accept || ((state_q == F_COS) && srsp.done);
		if (accept) begin
			sreq.quad = carrier_q[15:14] + 2'd1;
			sreq.frac = carrier_q[13:0];
		end else begin
			sreq.quad = item_ph_q[15:14];
			sreq.frac = item_ph_q[13:0];
		end
	end

	qdm_sin u_sin (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rsp    (srsp)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q       <= sample;
			item_ph_q <= carrier_q;
			emit_q    <= (sym_pos_q == {1'b0, period});
		end
		if (state_q == F_COS && srsp.done)
			c_q <= srsp.val;
		if (state_q == F_SIN && srsp.done)
			s_q <= srsp.val;
		if (state_q == F_MUL) begin
			// arithmetic shift gives floor rounding
			pi_q <= mul_i[PROD_W+PROD_SHIFT_C-1:PROD_SHIFT_C];
			pq_q <= mul_q[PROD_W+PROD_SHIFT_C-1:PROD_SHIFT_C];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			phase_step_q <= qdm_pkg::PHASE_STEP_RST;
			bit_period_q <= qdm_pkg::BIT_PERIOD_RST;
			carrier_q    <= 16'd0;
			sym_pos_q    <= 17'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q   <= F_COS;
						carrier_q <= carrier_q + phase_step_q;
						sym_pos_q <= (pos_next >= {period, 1'b0}) ? 17'd0 : pos_next;
					end
				end
				F_COS: begin
					if (srsp.done)
						state_q <= F_SIN;
				end
				F_SIN: begin
					if (srsp.done)
						state_q <= F_MUL;
				end
				F_MUL: state_q <= F_PUSH;
				F_PUSH: begin
					if (!mid_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
			if (cfg_valid) begin
				unique case (cfg_index)
					qdm_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
					qdm_pkg::REG_START_PHASE: carrier_q <= cfg_data;
					qdm_pkg::REG_BIT_PERIOD: bit_period_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- src/qdm_back.sv -----
// ----------------------------------------------------------------------------
// qdm_back
// Product history and one shared MAC per channel walking the sinc taps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qdm_back #(
	parameter int TAPS   = qdm_pkg::TAPS_DEF,
	parameter int PROD_W = qdm_pkg::SAMPLE_BITS_DEF + 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_empty,
	input  logic [2*PROD_W:0] mid_data,
	output logic              mid_pop,
	input  logic              out_full,
	output logic              out_push,
	output logic [1:0]        out_data
);

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_RUN   = 4'b0010,
		B_DRAIN = 4'b0100,
		B_OUT   = 4'b1000
	} bstate_t;

	localparam int AW    = $clog2(TAPS);
	localparam int CW    = $clog2(TAPS + 1);
	localparam int MW    = PROD_W + 16;
	localparam int ACC_W = MW + AW;

	bstate_t state_q;
	logic signed [PROD_W-1:0] mem_i [TAPS];
	logic signed [PROD_W-1:0] mem_q [TAPS];
	logic signed [15:0]       tap_rom [TAPS];
	logic [AW-1:0] newest_q;
	logic [AW-1:0] rd_addr_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] k_s1;
	logic [CW-1:0] fill_q;
	logic          v_s1;
	logic          v_s2;
	logic signed [PROD_W-1:0] d_i_s1;
	logic signed [PROD_W-1:0] d_q_s1;
	logic signed [MW-1:0] p_i_s2;
	logic signed [MW-1:0] p_q_s2;
	logic signed [ACC_W-1:0] acc_i_q;
	logic signed [ACC_W-1:0] acc_q_q;
	logic [AW-1:0] nw;
	logic          live;
	logic signed [PROD_W-1:0] op_i;
	logic signed [PROD_W-1:0] op_q;

	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		if (k == 0) begin : g_first
			assign tap_rom[k] = 16'sd32767;
		end else begin : g_rest
			localparam logic signed [15:0] S =
				qdm_pkg::sin_q15(32'(64'(k) * 64'(qdm_pkg::ANGLE_03)));
			localparam longint Mag = (S < 0) ? -longint'(S) : longint'(S);
			localparam longint Quo = (Mag * 20 + 3 * k) / (6 * k);
			assign tap_rom[k] = (S < 0) ? -16'(Quo) : 16'(Quo);
		end
	end

	assign nw       = (newest_q == AW'(TAPS - 1)) ? '0 : newest_q + AW'(1);
	assign mid_pop  = (state_q == B_IDLE) && !mid_empty;
	assign out_push = (state_q == B_OUT) && !out_full;
	assign out_data = {~acc_i_q[ACC_W-1], ~acc_q_q[ACC_W-1]};
	// entries older than the fill count were never written and read as zero
	assign live     = CW'(k_s1) < fill_q;
	assign op_i     = live ? d_i_s1 : '0;
	assign op_q     = live ? d_q_s1 : '0;

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			mem_i[nw] <= mid_data[2*PROD_W-1:PROD_W];
			mem_q[nw] <= mid_data[PROD_W-1:0];
		end
		d_i_s1 <= mem_i[rd_addr_q];
		d_q_s1 <= mem_q[rd_addr_q];
		k_s1   <= k_q;
		p_i_s2 <= MW'(op_i) * MW'(tap_rom[k_s1]);
		p_q_s2 <= MW'(op_q) * MW'(tap_rom[k_s1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			newest_q  <= '0;
			fill_q    <= '0;
			rd_addr_q <= '0;
			k_q       <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			acc_i_q   <= '0;
			acc_q_q   <= '0;
		end else begin
			v_s1 <= (state_q == B_RUN);
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_i_q <= acc_i_q + ACC_W'(p_i_s2);
				acc_q_q <= acc_q_q + ACC_W'(p_q_s2);
			end
			unique case (state_q)
				B_IDLE: begin
					if (mid_pop) begin
						newest_q <= nw;
						if (fill_q != CW'(TAPS))
							fill_q <= fill_q + CW'(1);
						if (mid_data[2*PROD_W]) begin
							state_q   <= B_RUN;
							rd_addr_q <= nw;
							k_q       <= '0;
							acc_i_q   <= '0;
							acc_q_q   <= '0;
						end
					end
				end
				B_RUN: begin
					rd_addr_q <= (rd_addr_q == '0) ? AW'(TAPS - 1) : rd_addr_q - AW'(1);
					k_q       <= k_q + AW'(1);
					if (k_q == AW'(TAPS - 1))
						state_q <= B_DRAIN;
				end
				B_DRAIN: begin
					if (!v_s1 && !v_s2)
						state_q <= B_OUT;
				end
				B_OUT: begin
					if (!out_full)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`QDM_ASSERT(a_fill_max, fill_q <= CW'(TAPS), "fill count beyond tap count")
	`QDM_ASSERT_IMP(a_no_pop_busy, state_q != B_IDLE, !mid_pop, "pop while filter busy")
	`QDM_ASSERT_IMP(a_drained, state_q == B_OUT, !v_s1 && !v_s2, "result before MAC drained")

endmodule

// ----- src/qpsk_demodulator_sinc_lowpass.sv -----
// Flow: an item is taken while the front is idle and mixed in two runs of the shared sine
// unit (cosine, then sine), one multiply and one hand-off to the mid queue; an item that ends
// a bit then passes through the back MAC over all TAPS taps, drains and is pushed as a result.
// The front takes a new item only after handing off the last one; bit items are further
// bounded by the pass of the single MAC per channel over the tap memory.
// Reset: arst_n async low clears control, registers load their reset values, history reads zero.
// ----------------------------------------------------------------------------
// qpsk_demodulator_sinc_lowpass
// Coherent QPSK demodulator with sinc low-pass filters and sign slicers.
// ----------------------------------------------------------------------------
module qpsk_demodulator_sinc_lowpass #(
	parameter int TAPS        = qdm_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = qdm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          empty,
	input  logic                          pop,
	output logic                          i_bit,
	output logic                          q_bit,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [qdm_pkg::CFG_W-1:0]     cfg_data
);

	localparam int PROD_W = SAMPLE_BITS + 12;

	logic              mid_push;
	logic [2*PROD_W:0] mid_wdata;
	logic              mid_full;
	logic              mid_pop;
	logic [2*PROD_W:0] mid_rdata;
	logic              mid_empty;
	logic              out_push;
	logic [1:0]        out_data;
	logic              out_full;
	logic [1:0]        res;

	assign cfg_ready = 1'b1;
	assign i_bit     = res[1];
	assign q_bit     = res[0];

	qdm_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.PROD_W      (PROD_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.sample    (sample),
		.full      (full),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mid_push  (mid_push),
		.mid_data  (mid_wdata),
		.mid_full  (mid_full)
	);

	qdm_fifo #(.W(2*PROD_W+1)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.rd     (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	qdm_back #(
		.TAPS   (TAPS),
		.PROD_W (PROD_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_rdata),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	qdm_fifo #(.W(2)) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (out_data),
		.full   (out_full),
		.rd     (pop),
		.rdata  (res),
		.empty  (empty)
	);

endmodule

// ----- bench/tb_qpsk_demodulator_sinc_lowpass.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qpsk_demodulator_sinc_lowpass
// Drives passband samples through the demodulator in phases, each under its own
// register setting. A behavioral demodulator predicts the I/Q decisions, which
// are checked in order against what the block hands out under random stalls.
// ----------------------------------------------------------------------------
module tb_qpsk_demodulator_sinc_lowpass;

	localparam int NTAPS = qdm_pkg::TAPS_DEF;
	localparam int SETTLE = 4 * NTAPS + 64;
	localparam logic [qdm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic i_bit;
		logic q_bit;
	} decision_t;

	logic                             clk;
	logic                             arst_n;
	logic                             push;
	logic                             full;
	logic signed [15:0]               sample;
	logic                             empty;
	logic                             pop;
	logic                             i_bit;
	logic                             q_bit;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [qdm_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [qdm_pkg::CFG_W-1:0]        cfg_data;

	qpsk_demodulator_sinc_lowpass u_dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .i_bit(i_bit), .q_bit(q_bit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// demodulator state
	int          tap_coef [NTAPS];
	longint      i_hist [NTAPS];
	longint      q_hist [NTAPS];
	int          newest;
	logic [15:0] step_reg, start_reg, period_reg, carrier;
	int          symbol_pos;

	logic signed [15:0] pending_samples [$];
	decision_t          expected_bits [$];

	int  n_errors, n_items, n_bits, n_cfg;
	bit  quiet_send;
	bit  hold_req;
	int  hold_cnt;
	int  send_gap, recv_gap;

	function automatic int carrier_sine(input logic [31:0] ph);
		logic [1:0]      quad;
		longint unsigned f, f2, p, r;
		quad = ph[31:30];
		f = ph[29:14];
		if (quad[0])
			f = 65536 - f;
		f2 = (f * f) >> 16;
		p = qdm_pkg::C9;
		p = qdm_pkg::C7 - ((p * f2) >> 16);
		p = qdm_pkg::C5 - ((p * f2) >> 16);
		p = qdm_pkg::C3 - ((p * f2) >> 16);
		p = qdm_pkg::C1 - ((p * f2) >> 16);
		r = (((p * f) >> 16) + 16384) >> 15;
		if (r > 32767)
			r = 32767;
		return quad[1] ? -int'(r) : int'(r);
	endfunction

	task automatic clear_demod();
		longint unsigned mag;
		int              s;
		tap_coef[0] = 32767;
		for (int k = 1; k < NTAPS; k++) begin
			s = carrier_sine(32'(longint'(k) * qdm_pkg::ANGLE_03));
			mag = (s < 0) ? -s : s;
			mag = (mag * 20 + 3 * k) / (6 * k);
			tap_coef[k] = (s < 0) ? -int'(mag) : int'(mag);
		end
		foreach (i_hist[k]) begin
			i_hist[k] = 0;
			q_hist[k] = 0;
		end
		newest = 0;
		step_reg = qdm_pkg::PHASE_STEP_RST;
		start_reg = '0;
		period_reg = qdm_pkg::BIT_PERIOD_RST;
		carrier = '0;
		symbol_pos = 0;
	endtask

	task automatic demod_sample(input logic signed [15:0] x);
		longint    c, s, acc_i, acc_q;
		int        idx, per;
		decision_t d;
		c = carrier_sine({carrier, 16'd0} + 32'h4000_0000);
		s = carrier_sine({carrier, 16'd0});
		per = (period_reg == 0) ? 1 : int'(period_reg);
		newest = (newest + 1 >= NTAPS) ? 0 : newest + 1;
		i_hist[newest] = (longint'(x) * c) >>> qdm_pkg::PROD_SHIFT;
		q_hist[newest] = (longint'(x) * s) >>> qdm_pkg::PROD_SHIFT;
		acc_i = 0;
		acc_q = 0;
		idx = newest;
		for (int k = 0; k < NTAPS; k++) begin
			acc_i += tap_coef[k] * i_hist[idx];
			acc_q += tap_coef[k] * q_hist[idx];
			idx = (idx == 0) ? NTAPS - 1 : idx - 1;
		end
		if (symbol_pos == per) begin
			d.i_bit = (acc_i < 0) ? 1'b0 : 1'b1;
			d.q_bit = (acc_q < 0) ? 1'b0 : 1'b1;
			expected_bits.insert(expected_bits.size(), d);
		end
		symbol_pos++;
		if (symbol_pos >= 2 * per)
			symbol_pos = 0;
		carrier = carrier + step_reg;
	endtask

	task automatic report(input string what, input logic got, input logic want);
		n_errors++;
		$display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $realtime);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic add_sample(input logic signed [15:0] x);
		pending_samples.insert(pending_samples.size(), x);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		logic               nxt_push;
		logic signed [15:0] nxt_sample;
		if (!arst_n) begin
			push <= 1'b0;
			sample <= '0;
			send_gap = 0;
		end else begin
			nxt_push = push;
			nxt_sample = sample;
			if (push && !full) begin
				demod_sample(sample);
				n_items++;
				nxt_push = 1'b0;
			end
			if (!nxt_push) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_samples.size() > 0) begin
					nxt_push = 1'b1;
					nxt_sample = pending_samples.pop_front();
					send_gap = quiet_send ? 0 : pick_gap();
				end
			end
			push <= nxt_push;
			sample <= nxt_sample;
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		decision_t d;
		if (!arst_n) begin
			pop <= 1'b0;
			hold_cnt = 0;
			recv_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_bits.size() == 0) begin
					report("unexpected item", i_bit, 1'bx);
				end else begin
					d = expected_bits.pop_front();
					n_bits++;
					if (i_bit !== d.i_bit) report("i_bit", i_bit, d.i_bit);
					if (q_bit !== d.q_bit) report("q_bit", q_bit, d.q_bit);
				end
			end
			if (hold_req)
				hold_cnt = 2500;
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				recv_gap = quiet_send ? 0 : pick_gap();
			end
		end
	end

	task automatic write_reg(input logic [qdm_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
		case (idx)
			qdm_pkg::REG_PHASE_STEP: step_reg = val;
			qdm_pkg::REG_START_PHASE: begin
				start_reg = val;
				carrier = val;
			end
			qdm_pkg::REG_BIT_PERIOD: period_reg = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || push || expected_bits.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// mostly modulated QPSK-like carrier, some plain noise
	task automatic load_phase(input int n);
		logic [15:0] tx_phase, tx_step;
		int          amp, sym, run;
		tx_phase = $urandom;
		tx_step = step_reg;
		sym = 0;
		run = 0;
		for (int k = 0; k < n; k++) begin
			if (run == 0) begin
				sym = $urandom_range(3);
				run = $urandom_range(1, 2 * ((period_reg == 0) ? 1 : period_reg));
				amp = $urandom_range(1000, 32767);
			end
			run--;
			if ($urandom_range(9) == 0)
				add_sample(16'($urandom));
			else
				add_sample(16'((amp * carrier_sine(
					{tx_phase + 16'(sym * 16384 + 8192), 16'd0})) >>> 15));
			tx_phase += tx_step;
		end
	endtask

	initial begin
		int per;
		logic signed [15:0] corners [7];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		quiet_send = 1'b0;
		n_errors = 0;
		n_items = 0;
		n_bits = 0;
		n_cfg = 0;
		clear_demod();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and sign changes at reset settings
		corners = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh5555,
			-16'sh5556};
		foreach (corners[k])
			add_sample(corners[k]);
		for (int k = 0; k < 13; k++)
			add_sample((k % 2) ? -16'sh8000 : 16'sh7fff);
		drain();

		// zero period acts as one, extreme phases; unknown index has no effect
		write_reg(qdm_pkg::REG_BIT_PERIOD, 16'd0);
		write_reg(qdm_pkg::REG_PHASE_STEP, 16'hffff);
		write_reg(qdm_pkg::REG_START_PHASE, 16'hffff);
		write_reg(REG_UNUSED, 16'h0001);
		load_phase(20);
		drain();

		// period larger than the run: no decisions
		write_reg(qdm_pkg::REG_BIT_PERIOD, 16'hffff);
		write_reg(qdm_pkg::REG_PHASE_STEP, 16'd0);
		load_phase(10);
		drain();

		// long period, then shrink it while the bit counter is still below the new end
		write_reg(qdm_pkg::REG_BIT_PERIOD, 16'd40);
		load_phase(70);
		drain();
		write_reg(qdm_pkg::REG_BIT_PERIOD, 16'd3);
		write_reg(qdm_pkg::REG_START_PHASE, 16'd0);
		load_phase(40);
		drain();

		// back-pressure: receiver stalls while samples keep coming
		write_reg(qdm_pkg::REG_BIT_PERIOD, 16'd1);
		quiet_send = 1'b1;
		load_phase(200);
		@(posedge clk);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		drain();
		quiet_send = 1'b0;

		for (int ph = 0; ph < 10; ph++) begin
			per = $urandom_range(1, 6);
			write_reg(qdm_pkg::REG_BIT_PERIOD, 16'(per));
			case ($urandom_range(3))
				0: write_reg(qdm_pkg::REG_PHASE_STEP, 16'd0);
				1: write_reg(qdm_pkg::REG_PHASE_STEP, 16'hffff);
				default: write_reg(qdm_pkg::REG_PHASE_STEP, 16'($urandom));
			endcase
			write_reg(qdm_pkg::REG_START_PHASE, 16'($urandom));
			quiet_send = (ph % 3 == 2);
			load_phase(50);
			drain();
		end

		$display("summary: %0d samples in, %0d decisions checked, %0d register writes",
			n_items, n_bits, n_cfg);
		$display("summary: periods 0..65535, phase steps 0..65535, long receiver stall");
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("status: fail");
		$finish;
	end

endmodule
